// File: hdl/patb_pkg.sv
// Package for the particle affine transform / bounding-box core.
// Shared types and constants; no dependencies.
package patb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // position fraction bits; positions pass through the datapath in this format
  localparam int unsigned PosFracBits = 16;

  localparam logic [CfgIdxW-1:0] RegCenterXy = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterZ  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegShiftXy  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShiftZ   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScaleXyz = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRotQuat  = 3'd5;

  localparam logic [47:0] ScaleReset = 48'h0100_0100_0100;
  localparam logic [63:0] QuatReset  = 64'h7FFF_0000_0000_0000;
  localparam logic signed [31:0] MatOne = 32'sh2000_0000;

  // back part: run, or rebuild the rotation matrix for a list start
  typedef enum logic [1:0] {StRun, StBuild1, StBuild2} back_st_e;

  // Word handed from the front part to the back part through the queue.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [63:0]        colour;
    logic               list_end;
    logic               list_start;
  } front_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hdl/patb_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing else.
interface patb_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/patb_front.sv
// Front part: computes the scaled point v = sat((s*(p+c+t) - 256c + 128) >> 8).
// Depends on patb_pkg. Two register stages, stall-coupled.
module patb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [31:0]        pos_x_i,
  input  logic signed [31:0]        pos_y_i,
  input  logic signed [31:0]        pos_z_i,
  input  logic [63:0]               colour_i,
  input  logic                      list_end_i,
  input  logic [95:0]               center_i,
  input  logic [95:0]               shift_i,
  input  logic [47:0]               scale_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output patb_pkg::front_word_t     out_word_o
);
  logic               s1_valid_q, s1_valid_d;
  logic signed [33:0] a_q [3];
  logic [63:0]        col_q;
  logic               end_q, start_q, start_d, lstart_q;
  logic               out_valid_q;
  patb_pkg::front_word_t word_q, word_d;
  logic adv2, adv1;
  logic signed [63:0] b [3], r [3];
  logic signed [31:0] pp [3], cc [3], tt [3];

  assign adv2 = !out_valid_q || out_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;
  assign out_valid_o = out_valid_q;
  assign out_word_o = word_q;
  assign pp[0] = pos_x_i; assign pp[1] = pos_y_i; assign pp[2] = pos_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cc[i] = center_i[32*i +: 32];
      tt[i] = shift_i[32*i +: 32];
    end
  end

  // stage 2 scale and round
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b[i] = 64'(signed'(scale_i[16*i +: 16])) * 64'(a_q[i])
             - (64'(cc[i]) <<< 8) + 64'sd128;
      r[i] = b[i] >>> 8;
    end
    word_d.vx = patb_pkg::sat32(r[0]);
    word_d.vy = patb_pkg::sat32(r[1]);
    word_d.vz = patb_pkg::sat32(r[2]);
    word_d.colour = col_q;
    word_d.list_end = end_q;
    word_d.list_start = start_q;
    s1_valid_d = in_valid_i ? 1'b1 : 1'b0;
    start_d = lstart_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      lstart_q <= 1'b1;
    end else begin
      if (adv1) begin
        s1_valid_q <= s1_valid_d;
        if (in_valid_i) lstart_q <= list_end_i;
      end
      if (adv2) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      for (int i = 0; i < 3; i++)
        a_q[i] <= 34'(pp[i]) + 34'(cc[i]) + 34'(tt[i]);
      col_q <= colour_i;
      end_q <= list_end_i;
      start_q <= start_d;
    end
    if (adv2 && s1_valid_q) word_q <= word_d;
  end
endmodule

// File: hdl/patb_fifo.sv
// Small two-entry queue between front and back parts.
// Depends on patb_pkg for the word type.
module patb_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  patb_pkg::front_word_t in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output patb_pkg::front_word_t out_word_o
);
  patb_pkg::front_word_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_word_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_word_i;
  end
endmodule

// File: hdl/patb_back.sv
// Back part: rotation by the quaternion matrix, saturation and list box.
// Depends on patb_pkg. Matrix rebuilt on list start; three pipeline stages.
module patb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  patb_pkg::front_word_t in_word_i,
  input  logic [63:0]           quat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o,
  output logic signed [31:0]    out_z_o,
  output logic [63:0]           colour_o,
  output logic [191:0]          box_o,
  output logic                  list_end_o
);
  patb_pkg::back_st_e st_q, st_d;
  logic signed [31:0] mat_q [9];
  logic signed [31:0] pr_q [9];
  logic signed [63:0] prd_q [9];
  logic s1_q, s2_q, ov_q;
  logic [63:0] col1_q, col2_q;
  logic end1_q, end2_q, st1_q, st2_q;
  logic signed [31:0] o_q [3], lo_q [3], hi_q [3];
  logic adv3, adv2, adv1, take;
  logic signed [31:0] v [3], o [3];
  logic signed [63:0] acc [3];
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] m_d [9];

  assign qw = quat_i[63:48]; assign qx = quat_i[47:32];
  assign qy = quat_i[31:16]; assign qz = quat_i[15:0];
  assign v[0] = in_word_i.vx; assign v[1] = in_word_i.vy; assign v[2] = in_word_i.vz;

  assign adv3 = !ov_q || out_ready_i;
  assign adv2 = !s2_q || adv3;
  assign adv1 = !s1_q || adv2;
  // a list-start word is held until StBuild2 while the matrix is rebuilt
  assign in_ready_o = adv1 && (st_q == patb_pkg::StBuild2 ||
                               !(in_valid_i && in_word_i.list_start));
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      patb_pkg::StRun: begin
        if (in_valid_i && in_word_i.list_start && adv1) st_d = patb_pkg::StBuild1;
      end
      patb_pkg::StBuild1: st_d = patb_pkg::StBuild2;
      patb_pkg::StBuild2: begin
        if (take) st_d = patb_pkg::StRun;
      end
      default: st_d = patb_pkg::StRun;
    endcase
  end

  // exact sums, saturated; one multiplier pass per cycle except in StBuild2
  always_comb begin
    m_d[0] = patb_pkg::sat32(64'(patb_pkg::MatOne) - 64'(pr_q[0]) - 64'(pr_q[1]));
    m_d[1] = patb_pkg::sat32(64'(pr_q[2]) - 64'(pr_q[3]));
    m_d[2] = patb_pkg::sat32(64'(pr_q[4]) + 64'(pr_q[5]));
    m_d[3] = patb_pkg::sat32(64'(pr_q[2]) + 64'(pr_q[3]));
    m_d[4] = patb_pkg::sat32(64'(patb_pkg::MatOne) - 64'(pr_q[8]) - 64'(pr_q[1]));
    m_d[5] = patb_pkg::sat32(64'(pr_q[6]) - 64'(pr_q[7]));
    m_d[6] = patb_pkg::sat32(64'(pr_q[4]) - 64'(pr_q[5]));
    m_d[7] = patb_pkg::sat32(64'(pr_q[6]) + 64'(pr_q[7]));
    m_d[8] = patb_pkg::sat32(64'(patb_pkg::MatOne) - 64'(pr_q[8]) - 64'(pr_q[0]));
  end

  // row sums, round half up, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = prd_q[3*i] + prd_q[3*i+1] + prd_q[3*i+2] + 64'sd67108864;
      o[i] = patb_pkg::sat32(acc[i] >>> 27);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= patb_pkg::StRun;
      s1_q <= 1'b0; s2_q <= 1'b0; ov_q <= 1'b0;
      for (int i = 0; i < 9; i++) mat_q[i] <= (i % 4 == 0) ? patb_pkg::MatOne : 32'sd0;
    end else begin
      st_q <= st_d;
      if (st_q == patb_pkg::StBuild2) for (int i = 0; i < 9; i++) mat_q[i] <= m_d[i];
      if (adv1) s1_q <= take;
      if (adv2) s2_q <= s1_q;
      if (adv3) ov_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == patb_pkg::StBuild1 || st_q == patb_pkg::StRun) begin
      pr_q[0] <= 32'(qy * qy); pr_q[1] <= 32'(qz * qz);
      pr_q[2] <= 32'(qx * qy); pr_q[3] <= 32'(qw * qz);
      pr_q[4] <= 32'(qx * qz); pr_q[5] <= 32'(qw * qy);
      pr_q[6] <= 32'(qy * qz); pr_q[7] <= 32'(qw * qx);
      pr_q[8] <= 32'(qx * qx);
    end
    if (adv1 && take) begin
      for (int i = 0; i < 9; i++)
        prd_q[i] <= (64'(st_q == patb_pkg::StBuild2 ? m_d[i] : mat_q[i]) *
                     64'(v[i % 3])) >>> 2;
      col1_q <= in_word_i.colour; end1_q <= in_word_i.list_end;
      st1_q <= in_word_i.list_start;
    end
    if (adv2 && s1_q) begin
      for (int i = 0; i < 3; i++) o_q[i] <= o[i];
      col2_q <= col1_q; end2_q <= end1_q; st2_q <= st1_q;
    end
    if (adv3 && s2_q) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= (st2_q || o_q[i] < lo_q[i]) ? o_q[i] : lo_q[i];
        hi_q[i] <= (st2_q || o_q[i] > hi_q[i]) ? o_q[i] : hi_q[i];
      end
      colour_o <= col2_q; list_end_o <= end2_q;
      out_x_o <= o_q[0]; out_y_o <= o_q[1]; out_z_o <= o_q[2];
    end
  end

  assign out_valid_o = ov_q;
  assign box_o = {hi_q[2], hi_q[1], hi_q[0], lo_q[2], lo_q[1], lo_q[0]};
endmodule

// File: hdl/particle_affine_transform_bbox_core.sv
// Particle affine transform core: p' = R*(S*(p+c+t) - c), with running list box.
// Channels: in_if (sink) takes a position, colour and list-end word; out_if
// (source) delivers the transformed position, colour, the list box so far
// and the list-end mark. Configuration: cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must write it only while no word is in flight (the core does not check).
// An accepted word passes the two front stages, the queue and the three back
// stages before it shows on out_if. The first word of each list is held until
// StBuild2 while the 3x3 rotation matrix is rebuilt from the quaternion
// register (nine 16x16 products, then sums).
// Throughput: one word per cycle inside a list while out_if is ready; a word
// that starts a list is not taken until the matrix is rebuilt.
// Centre, shift and scale registers act at once; the quaternion acts at the
// next list start. Reset gives identity rotation, unit scale, zero centre and
// shift, and marks the next word as a list start.
// When the receiver stalls, each part holds its registers; up to seven words
// (two front, two queued, three back) are taken before in_if.ready drops.
module particle_affine_transform_bbox_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  patb_if.sink                              in_if,
  patb_if.source                            out_if,
  input  logic                              cfg_we_i,
  input  logic [patb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [patb_pkg::CfgDataW-1:0]     cfg_data_i
);
  logic [63:0] center_xy_q, shift_xy_q, quat_q;
  logic [31:0] center_z_q, shift_z_q;
  logic [47:0] scale_q;
  logic f_valid, f_ready, q_valid, q_ready;
  patb_pkg::front_word_t f_word, q_word;
  logic [191:0] box;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_xy_q <= '0; center_z_q <= '0; shift_xy_q <= '0; shift_z_q <= '0;
      scale_q <= patb_pkg::ScaleReset; quat_q <= patb_pkg::QuatReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        patb_pkg::RegCenterXy: center_xy_q <= cfg_data_i;
        patb_pkg::RegCenterZ:  center_z_q <= cfg_data_i[31:0];
        patb_pkg::RegShiftXy:  shift_xy_q <= cfg_data_i;
        patb_pkg::RegShiftZ:   shift_z_q <= cfg_data_i[31:0];
        patb_pkg::RegScaleXyz: scale_q <= cfg_data_i[47:0];
        patb_pkg::RegRotQuat:  quat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  patb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .pos_x_i(in_if.data.pos_x), .pos_y_i(in_if.data.pos_y), .pos_z_i(in_if.data.pos_z),
    .colour_i(in_if.data.colour_in), .list_end_i(in_if.data.list_end_in),
    .center_i({center_z_q, center_xy_q}), .shift_i({shift_z_q, shift_xy_q}),
    .scale_i(scale_q),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_word_o(f_word)
  );

  patb_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_word_i(f_word),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_word_o(q_word)
  );

  patb_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_word_i(q_word),
    .quat_i(quat_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_x_o(out_if.data.out_x), .out_y_o(out_if.data.out_y), .out_z_o(out_if.data.out_z),
    .colour_o(out_if.data.colour_out), .box_o(box),
    .list_end_o(out_if.data.list_end_out)
  );

  assign out_if.data.min_x = box[31:0];
  assign out_if.data.min_y = box[63:32];
  assign out_if.data.min_z = box[95:64];
  assign out_if.data.max_x = box[127:96];
  assign out_if.data.max_y = box[159:128];
  assign out_if.data.max_z = box[191:160];
endmodule

// File: hdl/patb_checker.sv
// Port-level assertions for the transform core, bound to the top level.
// Depends only on the top level's ports.
module patb_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic list_end_out_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("out valid dropped");
  a_end_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(list_end_out_i)) else $error("end mark changed");
  a_no_out_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i) else $error("output after reset");
  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_ready_i})) else $error("input handshake unknown");
endmodule

bind particle_affine_transform_bbox_core patb_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .list_end_out_i(out_if.data.list_end_out)
);

// File: dv/tb_patb_pkg.sv
`timescale 1ns / 100ps
// Testbench word types for the particle transform core channels.
// Depends on nothing else; used by the checker and the testbench top.
package tb_patb_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [63:0]        colour_in;
    logic               list_end_in;
  } particle_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [63:0]        colour_out;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic               list_end_out;
  } particle_out_t;

endpackage

// File: dv/patb_checker.sv
`timescale 1ns / 100ps
// Checker for the particle transform core: watches both channels and the
// register port, predicts each output word and compares. Needs patb_pkg, tb_patb_pkg.
module patb_checker
  import patb_pkg::*;
  import tb_patb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  particle_in_t        in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  particle_out_t       out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  outstanding_o,
  output int                  fail_cnt_o
);

  particle_out_t expected_words[$];
  logic [63:0] center_xy, shift_xy, rot_quat;
  logic [31:0] center_z, shift_z;
  logic [47:0] scale_xyz;
  longint      rot_m[9];
  longint      box_lo[3], box_hi[3];
  logic        at_list_start;

  function automatic longint sat32_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx16(logic [15:0] h);
    return longint'(signed'(h));
  endfunction

  function automatic longint sx32(logic [31:0] h);
    return longint'(signed'(h));
  endfunction

  task automatic rebuild_matrix();
    longint w, x, y, z;
    w = sx16(rot_quat[63:48]); x = sx16(rot_quat[47:32]);
    y = sx16(rot_quat[31:16]); z = sx16(rot_quat[15:0]);
    rot_m[0] = sat32_l(longint'(MatOne) - (y*y + z*z));
    rot_m[1] = sat32_l(x*y - w*z);
    rot_m[2] = sat32_l(x*z + w*y);
    rot_m[3] = sat32_l(x*y + w*z);
    rot_m[4] = sat32_l(longint'(MatOne) - (x*x + z*z));
    rot_m[5] = sat32_l(y*z - w*x);
    rot_m[6] = sat32_l(x*z - w*y);
    rot_m[7] = sat32_l(y*z + w*x);
    rot_m[8] = sat32_l(longint'(MatOne) - (x*x + y*y));
  endtask

  // Transform one particle and advance the running list box.
  task automatic transform_particle(input particle_in_t p);
    longint c[3], t[3], s[3], pin[3], v[3], o[3], acc;
    particle_out_t w;
    c[0] = sx32(center_xy[31:0]); c[1] = sx32(center_xy[63:32]); c[2] = sx32(center_z);
    t[0] = sx32(shift_xy[31:0]);  t[1] = sx32(shift_xy[63:32]);  t[2] = sx32(shift_z);
    s[0] = sx16(scale_xyz[15:0]); s[1] = sx16(scale_xyz[31:16]); s[2] = sx16(scale_xyz[47:32]);
    pin[0] = p.pos_x; pin[1] = p.pos_y; pin[2] = p.pos_z;
    if (at_list_start) rebuild_matrix();
    for (int i = 0; i < 3; i++)
      v[i] = sat32_l((s[i] * (pin[i] + c[i] + t[i]) - c[i] * 256 + 128) >>> 8);
    for (int i = 0; i < 3; i++) begin
      acc = ((rot_m[3*i] * v[0]) >>> 2) + ((rot_m[3*i+1] * v[1]) >>> 2)
          + ((rot_m[3*i+2] * v[2]) >>> 2);
      o[i] = sat32_l((acc + (64'sd1 << 26)) >>> 27);
      if (at_list_start || o[i] < box_lo[i]) box_lo[i] = o[i];
      if (at_list_start || o[i] > box_hi[i]) box_hi[i] = o[i];
    end
    at_list_start = p.list_end_in;
    w.out_x = o[0][31:0]; w.out_y = o[1][31:0]; w.out_z = o[2][31:0];
    w.colour_out = p.colour_in;
    w.min_x = box_lo[0][31:0]; w.min_y = box_lo[1][31:0]; w.min_z = box_lo[2][31:0];
    w.max_x = box_hi[0][31:0]; w.max_y = box_hi[1][31:0]; w.max_z = box_hi[2][31:0];
    w.list_end_out = p.list_end_in;
    expected_words.push_back(w);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    particle_out_t e, a;
    if (!rst_ni) begin
      center_xy = '0; center_z = '0; shift_xy = '0; shift_z = '0;
      scale_xyz = ScaleReset; rot_quat = QuatReset;
      at_list_start = 1'b1;
      expected_words.delete();
      fail_cnt_o = 0;
      rebuild_matrix();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCenterXy: center_xy = cfg_data_i;
          RegCenterZ:  center_z  = cfg_data_i[31:0];
          RegShiftXy:  shift_xy  = cfg_data_i;
          RegShiftZ:   shift_z   = cfg_data_i[31:0];
          RegScaleXyz: scale_xyz = cfg_data_i[47:0];
          RegRotQuat:  rot_quat  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) transform_particle(in_data_i);
      if (out_valid_i && out_ready_i) begin
        a = out_data_i;
        if (expected_words.size() == 0) begin
          $error("output word with nothing expected: %h", a);
          fail_cnt_o++;
        end else begin
          e = expected_words.pop_front();
          check_field("out_x", e.out_x, a.out_x);
          check_field("out_y", e.out_y, a.out_y);
          check_field("out_z", e.out_z, a.out_z);
          check_field("colour_out", e.colour_out, a.colour_out);
          check_field("min_x", e.min_x, a.min_x);
          check_field("min_y", e.min_y, a.min_y);
          check_field("min_z", e.min_z, a.min_z);
          check_field("max_x", e.max_x, a.max_x);
          check_field("max_y", e.max_y, a.max_y);
          check_field("max_z", e.max_z, a.max_z);
          check_field("list_end_out", e.list_end_out, a.list_end_out);
        end
      end
    end
    outstanding_o = expected_words.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for particle_affine_transform_bbox_core: clock, reset,
// stimulus, receiver stalls and verdict. Needs patb_pkg, patb_if, tb_patb_pkg, patb_checker.
module tb_top;
  import patb_pkg::*;
  import tb_patb_pkg::*;

  // indexes outside the register map
  localparam logic [CfgIdxW-1:0] RegUnmappedA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnmappedB = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int outstanding, fail_cnt;

  patb_if #(.T(particle_in_t))  in_if ();
  patb_if #(.T(particle_out_t)) out_if ();

  // receiver behavior, steered by the stimulus process
  int stall_pct = 0;
  int hold_req = 0, hold_done = 0, hold_left = 0;
  int words_sent = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  particle_affine_transform_bbox_core i_dut (
    .clk_i, .rst_ni, .in_if(in_if), .out_if(out_if),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  patb_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_data_i(in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .outstanding_o(outstanding), .fail_cnt_o(fail_cnt)
  );

  // Receiver: random stalls at the current rate; a hold request parks
  // ready low for a long stretch so the core fills and backs up its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // burst state of the sender
  int burst_left = 0;
  int gap_max = 4;

  // Send one word and wait for its handshake; gaps fall between bursts.
  task automatic send_word(input particle_in_t w);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain: drop valid, wait until all expected words are back, then let the pipeline settle.
  task automatic wait_idle();
    drop_valid();
    while (outstanding != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic logic [63:0] rand_q16x2();
    if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
    return {$urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
            $urandom_range(0, 32'h0010_0000) - 32'h0008_0000};
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 4))
      0: return 16'h0100;
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic particle_in_t rand_particle(input int end_pct);
    particle_in_t p;
    p.pos_x = rand_pos(); p.pos_y = rand_pos(); p.pos_z = rand_pos();
    p.colour_in = {$urandom(), $urandom()};
    p.list_end_in = ($urandom_range(0, 99) < end_pct);
    return p;
  endfunction

  function automatic particle_in_t mk(input logic [31:0] v, input logic e);
    particle_in_t p;
    p.pos_x = v; p.pos_y = v; p.pos_z = v;
    p.colour_in = {$urandom(), $urandom()};
    p.list_end_in = e;
    return p;
  endfunction

  initial begin
    int phase_len, end_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config (identity), field extremes, list boundaries.
    send_word(mk(32'h0000_0000, 1'b0));
    send_word(mk(32'h7FFF_FFFF, 1'b0));
    send_word(mk(32'h8000_0000, 1'b1));
    send_word(mk(32'hFFFF_FFFF, 1'b1));
    send_word(mk(32'h0001_0000, 1'b0));
    send_word('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
    wait_idle();
    // Extremes: all-negative quaternion, min and max scale, min and max centre/shift.
    cfg_write(RegCenterXy, 64'h7FFF_FFFF_8000_0000);
    cfg_write(RegCenterZ,  64'h7FFF_FFFF);
    cfg_write(RegShiftXy,  64'h8000_0000_7FFF_FFFF);
    cfg_write(RegShiftZ,   64'h8000_0000);
    cfg_write(RegScaleXyz, 64'h8000_7FFF_8000);
    cfg_write(RegRotQuat,  64'h8000_8000_8000_8000);
    cfg_write(RegUnmappedA, 64'hDEAD_BEEF_DEAD_BEEF);  // unmapped index: no effect
    cfg_write(RegUnmappedB, 64'h0);
    send_word(mk(32'h0000_0000, 1'b0));
    send_word(mk(32'h7FFF_FFFF, 1'b0));
    send_word(mk(32'h8000_0000, 1'b1));
    // Quaternion written mid-list: takes hold only at the next list start.
    send_word(mk(32'h0003_0000, 1'b0));
    wait_idle();
    cfg_write(RegRotQuat, 64'h7FFF_7FFF_7FFF_7FFF);
    cfg_write(RegScaleXyz, 64'h7FFF_8000_0100);
    send_word(mk(32'h0002_0000, 1'b0));
    send_word(mk(32'hFFFE_0000, 1'b1));
    send_word(mk(32'h1234_5678, 1'b0));
    send_word(mk(32'hEDCB_A988, 1'b1));
    wait_idle();

    // Random phases, each with its own configuration and handshake pressure.
    for (int ph = 0; words_sent < 720; ph++) begin
      cfg_write(RegCenterXy, rand_q16x2());
      cfg_write(RegCenterZ,  rand_q16x2() >> 32);
      cfg_write(RegShiftXy,  rand_q16x2());
      cfg_write(RegShiftZ,   rand_q16x2() >> 32);
      cfg_write(RegScaleXyz, {16'h0, rand_half(), rand_half(), rand_half()});
      if (ph % 3 == 0) cfg_write(RegRotQuat, {QuatReset[63:48], 48'h0});
      else cfg_write(RegRotQuat, {rand_half(), rand_half(), rand_half(), rand_half()});
      stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(10, 70);
      gap_max = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
      end_pct = (ph % 2 == 0) ? 5 : 25;
      if (ph == 1) hold_req++;
      phase_len = $urandom_range(60, 140);
      repeat (phase_len) send_word(rand_particle(end_pct));
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/patb_pkg.sv
hdl/patb_if.sv
hdl/patb_front.sv
hdl/patb_fifo.sv
hdl/patb_back.sv
hdl/particle_affine_transform_bbox_core.sv
hdl/patb_checker.sv
dv/tb_patb_pkg.sv
dv/patb_checker.sv
dv/tb_top.sv
